@@ src/jtt_pkg.sv @@
// Shared types and constants of the job tag tracker.
package jtt_pkg;

    localparam int MAX_SLOTS  = 32;
    localparam int SLOT_W     = 5;
    localparam int SIZE_W     = 6;
    localparam int ADDR_W     = 64;
    localparam int WORD_W     = 32;

    // Request kinds.
    localparam logic [1:0] REQ_ENQ    = 2'd0;
    localparam logic [1:0] REQ_DONE   = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // Result codes.
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_FULL    = 2'd1;
    localparam logic [1:0] RES_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] desc_addr;
        logic [WORD_W-1:0] job_status;
        logic [WORD_W-1:0] cancel_mask;
        logic [WORD_W-1:0] wait_mask;
    } t_req;

    typedef struct packed {
        logic [1:0]        result_code;
        logic [WORD_W-1:0] job_tag;
        logic [SLOT_W-1:0] slot_index;
        logic [SLOT_W-1:0] ring_index;
        logic [WORD_W-1:0] done_status;
        logic              was_awaited;
    } t_res;

endpackage

@@ src/jtt_addr_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module jtt_addr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/jtt_ctrl.sv @@
// Slot scan sequencer: busy bits, ring positions and the address table walk.
module jtt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [jtt_pkg::SIZE_W-1:0] i_size,
    input  logic                       i_start,
    input  jtt_pkg::t_req              i_req,
    output logic                       o_ready,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output jtt_pkg::t_res              o_res
);
    import jtt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           r_state, n_state;
    t_req                 r_req;
    logic [MAX_SLOTS-1:0] r_busy, n_busy;
    logic [SLOT_W-1:0]    r_in_pos, n_in_pos;
    logic [SLOT_W-1:0]    r_out_pos, n_out_pos;
    logic [SIZE_W-1:0]    r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    t_res                 r_res, n_res;

    logic [ADDR_W-1:0]    rdata;
    logic                 rd_en;
    logic                 wr_en;
    logic [WORD_W-1:0]    tag;
    logic                 busy_bit;
    logic                 hit;
    logic                 miss;
    logic                 issue;

    // Address table; only occupied slots are ever compared.
    jtt_addr_ram #(
        .DEPTH(MAX_SLOTS),
        .WIDTH(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_cmp_idx),
        .i_wdata(r_req.desc_addr),
        .i_re   (rd_en),
        .i_raddr(r_rd_idx[SLOT_W-1:0]),
        .o_rdata(rdata)
    );

    // Advance a ring position, wrapping at the ring size.
    function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] pos,
                                                  input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] nxt;
        nxt = {1'b0, pos} + SIZE_W'(1);
        if (nxt >= size) begin
            nxt = '0;
        end
        return nxt[SLOT_W-1:0];
    endfunction

    // Per-slot match test on the compare stage.
    always_comb begin
        tag      = WORD_W'(1) << r_cmp_idx;
        busy_bit = r_busy[r_cmp_idx];
        case (r_req.req_type)
            REQ_ENQ:    hit = r_cmp_vld && !busy_bit;
            REQ_DONE:   hit = r_cmp_vld && busy_bit && (rdata == r_req.desc_addr);
            REQ_CANCEL: hit = r_cmp_vld && busy_bit && (tag == r_req.cancel_mask);
            default:    hit = 1'b0;
        endcase
        issue = (r_state == ST_SCAN) && !hit && (r_rd_idx < i_size);
        miss  = (r_state == ST_SCAN) && !r_cmp_vld && (r_rd_idx >= i_size);
        rd_en = issue;
        wr_en = (r_state == ST_SCAN) && hit && (r_req.req_type == REQ_ENQ);
    end

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        n_in_pos  = r_in_pos;
        n_out_pos = r_out_pos;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = 1'b0;
        n_res     = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_start && (i_req.req_type != REQ_NONE)) begin
                    n_state  = ST_SCAN;
                    n_rd_idx = '0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[SLOT_W-1:0];
                    n_rd_idx  = r_rd_idx + SIZE_W'(1);
                end
                if (hit || miss) begin
                    n_state = ST_DONE;
                    n_res   = '0;
                end
                if (hit) begin
                    n_res.result_code = RES_OK;
                    n_res.job_tag     = tag;
                    n_res.slot_index  = r_cmp_idx;
                    case (r_req.req_type)
                        REQ_ENQ: begin
                            n_busy[r_cmp_idx] = 1'b1;
                            n_res.ring_index  = r_in_pos;
                            n_in_pos          = advance(r_in_pos, i_size);
                        end
                        REQ_DONE: begin
                            n_busy[r_cmp_idx] = 1'b0;
                            n_res.ring_index  = r_out_pos;
                            n_res.done_status = r_req.job_status;
                            n_res.was_awaited = |(tag & r_req.wait_mask);
                            n_out_pos         = advance(r_out_pos, i_size);
                        end
                        default: begin
                            n_busy[r_cmp_idx] = 1'b0;
                        end
                    endcase
                end else if (miss) begin
                    case (r_req.req_type)
                        REQ_ENQ: begin
                            n_res.result_code = RES_FULL;
                        end
                        REQ_DONE: begin
                            n_res.result_code = RES_NOMATCH;
                            n_res.ring_index  = r_out_pos;
                            n_out_pos         = advance(r_out_pos, i_size);
                        end
                        default: begin
                            n_res.result_code = RES_NOMATCH;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_busy    <= '0;
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_cmp_vld <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_in_pos  <= n_in_pos;
            r_out_pos <= n_out_pos;
            r_cmp_vld <= n_cmp_vld;
            r_rd_idx  <= n_rd_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == ST_IDLE)) begin
            r_req <= i_req;
        end
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

@@ src/job_tag_tracker.sv @@
// Job tag tracker top level: stream ports, ring size register and output register.
// An accepted request scans the slots in order, one table entry is read a cycle, and the
// result enters the output register after a match or after the last slot is compared.
// One item at a time; the next request is taken in the idle state that follows once the
// result enters the output register.
// Reset: synchronous active low; all slots free, both ring positions zero, ring size 32.
module job_tag_tracker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Ring size register write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [5:0]   i_cfg_data,
    // Request stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: desc_addr[63:0], job_status[95:64], cancel_mask[127:96], wait_mask[159:128]
    input  logic [159:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: job_tag[31:0], slot_index[36:32], ring_index[41:37], done_status[73:42],
    //        was_awaited[74], zero fill[79:75]
    output logic [79:0]  m_axis_tdata,
    // tuser: result_code[1:0]
    output logic [1:0]   m_axis_tuser
);
    import jtt_pkg::*;

    logic [SIZE_W-1:0] r_ring_size;
    logic [SIZE_W-1:0] eff_size;
    t_req              req;
    t_res              res;
    logic              ctrl_ready;
    logic              res_valid;
    logic              res_take;
    logic              r_m_tvalid;
    t_res              r_m_res;

    // Ring size register; out-of-range values are clamped on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= SIZE_W'(MAX_SLOTS);
        end else if (i_cfg_valid) begin
            r_ring_size <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_ring_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_ring_size > SIZE_W'(MAX_SLOTS)) begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end else begin
            eff_size = r_ring_size;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Unpack the request.
    assign req.req_type    = s_axis_tuser;
    assign req.desc_addr   = s_axis_tdata[63:0];
    assign req.job_status  = s_axis_tdata[95:64];
    assign req.cancel_mask = s_axis_tdata[127:96];
    assign req.wait_mask   = s_axis_tdata[159:128];

    assign s_axis_tready = ctrl_ready;

    jtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_size     (eff_size),
        .i_start    (s_axis_tvalid),
        .i_req      (req),
        .o_ready    (ctrl_ready),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res)
    );

    // Output register: loads when empty or being drained this cycle.
    assign res_take = res_valid && (!r_m_tvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_take) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tuser  = r_m_res.result_code;
    assign m_axis_tdata  = {5'b0, r_m_res.was_awaited, r_m_res.done_status,
                            r_m_res.ring_index, r_m_res.slot_index, r_m_res.job_tag};

endmodule

@@ tb/job_tag_tracker_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the job tag tracker: a directed table, then phases of random requests.
module job_tag_tracker_tb;
    import jtt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SCAN_SETTLE = 40;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_AT     = 300;
    localparam int LONG_HOLD   = 400;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [5:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // One line of the directed table: either a ring size write or a request.
    typedef struct {
        bit          is_cfg;
        logic [5:0]  value;
        t_req        req;
        bit          known;
        t_res        res;
    } t_script_row;

    t_script_row script[$];
    t_res        expected_outcomes[$];
    int          mismatches = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    // Shadow copy of the tracking table and ring positions.
    logic [MAX_SLOTS-1:0] tr_busy;
    logic [ADDR_W-1:0]    tr_addr [MAX_SLOTS];
    logic [SLOT_W-1:0]    tr_in_pos;
    logic [SLOT_W-1:0]    tr_out_pos;
    logic [SIZE_W-1:0]    tr_ring_size;

    job_tag_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Slots in use; a size of zero acts as one and anything above the table acts as full size.
    function automatic int active_slots();
        if (tr_ring_size == '0) return 1;
        if (tr_ring_size > MAX_SLOTS) return MAX_SLOTS;
        return int'(tr_ring_size);
    endfunction

    // A position at or above the ring size is used as it is and wraps on its next advance.
    function automatic logic [SLOT_W-1:0] next_pos(input logic [SLOT_W-1:0] p);
        int n;
        n = int'(p) + 1;
        if (n >= active_slots()) n = 0;
        return SLOT_W'(n);
    endfunction

    // Applies one request to the shadow table; returns 0 when the request yields no result.
    function automatic bit track_request(input t_req r, output t_res e);
        int lim;
        int s;
        lim = active_slots();
        e = '0;
        if (r.req_type == REQ_NONE) return 1'b0;
        if (r.req_type == REQ_ENQ) begin
            for (s = 0; s < lim; s++) begin
                if (!tr_busy[s]) begin
                    tr_busy[s] = 1'b1;
                    tr_addr[s] = r.desc_addr;
                    e.job_tag = 32'h1 << s;
                    e.slot_index = SLOT_W'(s);
                    e.ring_index = tr_in_pos;
                    tr_in_pos = next_pos(tr_in_pos);
                    return 1'b1;
                end
            end
            e.result_code = RES_FULL;
            return 1'b1;
        end
        if (r.req_type == REQ_DONE) begin
            // The output position is consumed whether or not a slot matches.
            e.result_code = RES_NOMATCH;
            e.ring_index = tr_out_pos;
            for (s = 0; s < lim; s++) begin
                if (tr_busy[s] && tr_addr[s] == r.desc_addr) begin
                    tr_busy[s] = 1'b0;
                    e.result_code = RES_OK;
                    e.job_tag = 32'h1 << s;
                    e.slot_index = SLOT_W'(s);
                    e.done_status = r.job_status;
                    e.was_awaited = |(e.job_tag & r.wait_mask);
                    break;
                end
            end
            tr_out_pos = next_pos(tr_out_pos);
            return 1'b1;
        end
        // Cancel: the mask must equal the tag of an occupied slot exactly.
        for (s = 0; s < lim; s++) begin
            if (tr_busy[s] && (32'h1 << s) == r.cancel_mask) begin
                tr_busy[s] = 1'b0;
                e.job_tag = 32'h1 << s;
                e.slot_index = SLOT_W'(s);
                return 1'b1;
            end
        end
        e.result_code = RES_NOMATCH;
        return 1'b1;
    endfunction

    // Draws a request of a kind set by enq_pct; completions and cancels mostly name jobs that are really outstanding.
    function automatic t_req pick_request(input int enq_pct);
        t_req r;
        int   roll;
        int   s;
        int   done_cut;
        int   busy_list[$];
        r.desc_addr   = {$urandom, $urandom};
        r.job_status  = $urandom;
        r.cancel_mask = $urandom;
        r.wait_mask   = $urandom;
        for (s = 0; s < MAX_SLOTS; s++) begin
            if (tr_busy[s]) busy_list.push_back(s);
        end
        s = busy_list.size() > 0 ? busy_list[$urandom_range(0, busy_list.size() - 1)] : -1;
        done_cut = enq_pct + (100 - enq_pct) * 6 / 10;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) begin
            r.req_type = REQ_ENQ;
            if (s >= 0 && $urandom_range(0, 9) == 0) r.desc_addr = tr_addr[s];
            else if ($urandom_range(0, 3) == 0) r.desc_addr = 64'($urandom_range(0, 15));
        end else if (roll < done_cut) begin
            r.req_type = REQ_DONE;
            if (s >= 0 && $urandom_range(0, 7) != 0) r.desc_addr = tr_addr[s];
        end else if (roll < 97) begin
            r.req_type = REQ_CANCEL;
            if (s >= 0 && $urandom_range(0, 3) != 0) begin
                r.cancel_mask = 32'h1 << s;
            end else begin
                case ($urandom_range(0, 2))
                    0: r.cancel_mask = '0;
                    1: r.cancel_mask = 32'h1 << $urandom_range(0, MAX_SLOTS - 1);
                    default: ;
                endcase
            end
        end else begin
            r.req_type = REQ_NONE;
        end
        return r;
    endfunction

    function automatic void add_cfg(input logic [5:0] value);
        t_script_row row;
        row.is_cfg = 1'b1;
        row.value  = value;
        row.req    = '0;
        row.known  = 1'b0;
        row.res    = '0;
        script.push_back(row);
    endfunction

    function automatic void add_row(input logic [1:0] kind, input logic [63:0] addr,
                                    input logic [31:0] status, input logic [31:0] cmask,
                                    input logic [31:0] wmask, input bit known, input t_res res);
        t_script_row row;
        row.is_cfg          = 1'b0;
        row.value           = '0;
        row.req.req_type    = kind;
        row.req.desc_addr   = addr;
        row.req.job_status  = status;
        row.req.cancel_mask = cmask;
        row.req.wait_mask   = wmask;
        row.known           = known;
        row.res             = res;
        script.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offers one request after a random gap and records its outcome once it is taken.
    task automatic send_request(input t_req r, input bit known, input t_res res);
        int   gap;
        t_res predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.wait_mask, r.cancel_mask, r.job_status, r.desc_addr};
        s_axis_tuser  <= r.req_type;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (track_request(r, predicted))
            expected_outcomes.push_back(known ? res : predicted);
    endtask

    // Waits until every result is back, then lets any scan still running finish.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (SCAN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [5:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tr_ring_size = value;
    endtask

    // Result side: random stalls, calm stretches, and one long hold that backs up the input.
    initial begin : result_sink
        int   stall;
        int   got;
        t_res want;
        stall = 0;
        got = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result: code %0d, tdata %h", m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("result_code", want.result_code, m_axis_tuser);
                    check_field("job_tag", want.job_tag, m_axis_tdata[31:0]);
                    check_field("slot_index", want.slot_index, m_axis_tdata[36:32]);
                    check_field("ring_index", want.ring_index, m_axis_tdata[41:37]);
                    check_field("done_status", want.done_status, m_axis_tdata[73:42]);
                    check_field("was_awaited", want.was_awaited, m_axis_tdata[74]);
                end
                got++;
                if (got % 100 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                if (got == HOLD_AT) stall = LONG_HOLD;
                else stall = rx_calm ? 0 : $urandom_range(0, 5);
            end else if (stall > 0) begin
                stall--;
            end
            m_axis_tready <= (stall == 0);
        end
    end

    initial begin : run_watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // Request side: directed table first, then random phases at several ring sizes.
    initial begin : request_source
        int         phase;
        int         sent;
        int         enq_pct;
        t_req       r;
        logic [5:0] phase_size [8];
        phase_size = '{6'd32, 6'd1, 6'd5, 6'd63, 6'd0, 6'd17, 6'd2, 6'd32};
        enq_pct = 50;
        tr_busy = '0;
        foreach (tr_addr[k]) tr_addr[k] = '0;
        tr_in_pos = '0;
        tr_out_pos = '0;
        tr_ring_size = 6'd32;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Known outcomes after reset, extremes of address and status, and rejected cancels.
        add_row(REQ_ENQ, '0, '0, '0, '0, 1, t_res'{RES_OK, 32'h1, 5'd0, 5'd0, 32'h0, 1'b0});
        add_row(REQ_ENQ, '1, '0, '0, '0, 1, t_res'{RES_OK, 32'h2, 5'd1, 5'd1, 32'h0, 1'b0});
        add_row(REQ_DONE, '1, '1, '0, '1, 1,
                t_res'{RES_OK, 32'h2, 5'd1, 5'd0, 32'hFFFF_FFFF, 1'b1});
        add_row(REQ_DONE, 64'h1234, '1, '0, '1, 1,
                t_res'{RES_NOMATCH, 32'h0, 5'd0, 5'd1, 32'h0, 1'b0});
        add_row(REQ_CANCEL, '0, '0, 32'h0, '0, 1, t_res'{RES_NOMATCH, '0, '0, '0, '0, 1'b0});
        add_row(REQ_CANCEL, '0, '0, 32'h3, '0, 1, t_res'{RES_NOMATCH, '0, '0, '0, '0, 1'b0});
        add_row(REQ_CANCEL, '0, '0, 32'h1, '0, 1, t_res'{RES_OK, 32'h1, 5'd0, 5'd0, '0, 1'b0});
        add_row(REQ_NONE, '1, '1, '1, '1, 0, '0);
        // A zero size acts as one slot; the input position above it is used as it is.
        add_cfg(6'd0);
        add_row(REQ_ENQ, 64'hA5A5_5A5A_0F0F_F0F0, '0, '0, '0, 0, '0);
        add_row(REQ_ENQ, 64'h1, '0, '0, '0, 1, t_res'{RES_FULL, '0, '0, '0, '0, 1'b0});
        add_row(REQ_DONE, 64'hA5A5_5A5A_0F0F_F0F0, 32'h1234_5678, '0, '0, 0, '0);
        add_row(REQ_CANCEL, '0, '0, 32'h8000_0000, '0, 1,
                t_res'{RES_NOMATCH, '0, '0, '0, '0, 1'b0});
        // Oversized register value acts as the full table.
        add_cfg(6'd63);
        add_row(REQ_ENQ, '1, '0, '0, '0, 0, '0);
        add_row(REQ_DONE, '1, 32'h8000_0001, '0, 32'hFFFF_FFFE, 0, '0);

        foreach (script[n]) begin
            if (script[n].is_cfg) write_ring_size(script[n].value);
            else send_request(script[n].req, script[n].known, script[n].res);
        end

        for (phase = 0; phase < 8; phase++) begin
            write_ring_size(phase_size[phase]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (sent % 40 == 0) enq_pct = 20 + 30 * $urandom_range(0, 2);
                if (sent % 60 == 0) tx_calm = ($urandom_range(0, 2) == 0);
                r = pick_request(enq_pct);
                send_request(r, 1'b0, '0);
                if (r.req_type != REQ_NONE) sent++;
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/jtt_pkg.sv
src/jtt_addr_ram.sv
src/jtt_ctrl.sv
src/job_tag_tracker.sv
tb/job_tag_tracker_tb.sv
